[hw/rtl/assert_macros.svh]
// Assertion helpers for the triangulation core.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check on clk, muted while rst is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/trmt_pkg.sv]
// Shared widths and register indexes for the two-ray midpoint triangulation core.
// No dependencies; used by trmt_div and the top level.
package trmt_pkg;

  localparam int VEC_W  = 32;   // ray and baseline components
  localparam int DOT_W  = 66;   // dot products
  localparam int WIDE_W = 132;  // determinant and ray numerators
  localparam int NUM_W  = 166;  // point numerator, offset to be non-negative
  localparam int DEN_W  = 130;  // twice the determinant
  localparam int QUO_W  = 32;   // point component

  typedef enum logic [1:0] {
    REG_BASE_X = 2'd0,
    REG_BASE_Y = 2'd1,
    REG_BASE_Z = 2'd2,
    REG_THR    = 2'd3
  } reg_idx_t;

endpackage

[hw/rtl/trmt_div.sv]
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on trmt_pkg for default widths.
module trmt_div #(
  parameter int NUM_W = trmt_pkg::NUM_W,
  parameter int DEN_W = trmt_pkg::DEN_W,
  parameter int QUO_W = trmt_pkg::QUO_W
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  logic [NUM_W-1:0] rem_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic [NUM_W-1:0] trial;
    logic             fits;

    if (s == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    // Divisor aligned to the quotient bit this stage resolves.
    assign trial = NUM_W'(den_in) << (QUO_W - 1 - s);
    assign fits  = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= fits ? (rem_in - trial) : rem_in;
        den_q[s] <= den_in;
        quo_q[s] <= quo_in | (fits ? (QUO_W'(1) << (QUO_W - 1 - s)) : '0);
      end
    end
  end

  assign quo = quo_q[QUO_W-1];

endmodule

[hw/rtl/two_ray_midpoint_triangulation_core.sv]
// Two-ray midpoint triangulation, fully pipelined, top level.
// Depends on trmt_pkg, trmt_div and assert_macros.svh.
//
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------
//  in      | in_valid / in_ready   | ray0_x..z, ray1_x..z (s32)
//  out     | out_valid / out_ready | point_x..z (s32), point_valid
//  cfg     | cfg_we                | cfg_index, cfg_data
//
// One ray pair per cycle while in_ready is high; nine arithmetic stages, 32 divider stages
// and the output register lie between input transfer and output transfer.
// rst clears the valid bits and the configuration registers; no memory to sweep.
// A stalled output parks one result in a skid register; only then does
// in_ready drop and the whole pipeline hold.
`include "assert_macros.svh"

module two_ray_midpoint_triangulation_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [31:0] ray0_x,
  input  logic signed [31:0] ray0_y,
  input  logic signed [31:0] ray0_z,
  input  logic signed [31:0] ray1_x,
  input  logic signed [31:0] ray1_y,
  input  logic signed [31:0] ray1_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic signed [31:0] point_z,
  output logic        point_valid,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int VW = trmt_pkg::VEC_W;
  localparam int DW = trmt_pkg::DOT_W;
  localparam int WW = trmt_pkg::WIDE_W;
  localparam int NW = trmt_pkg::NUM_W;
  localparam int EW = trmt_pkg::DEN_W;
  localparam int QW = trmt_pkg::QUO_W;
  localparam int PW = 68;  // partial product width

  typedef struct packed {
    logic       valid;
    logic       ok;
    logic [2:0] sat_hi;
    logic [2:0] sat_lo;
  } side_t;

  // Partials of a 66 x 66 product: lo halves unsigned, hi halves signed.
  function automatic logic signed [PW-1:0] pp66(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b,
                                                 input logic ah, input logic bh);
    logic signed [33:0] ea;
    logic signed [33:0] eb;
    ea = ah ? $signed(a[DW-1:32]) : $signed({2'b00, a[31:0]});
    eb = bh ? $signed(b[DW-1:32]) : $signed({2'b00, b[31:0]});
    return PW'(ea) * PW'(eb);
  endfunction

  // 32-bit signed value times one chunk of a wide value (low chunks 32-bit unsigned, top chunk 36-bit signed).
  function automatic logic signed [PW-1:0] ppchunk(input logic signed [VW-1:0] a,
                                                    input logic signed [WW-1:0] w,
                                                    input int k);
    logic signed [35:0] c;
    c = (k == 3) ? $signed(w[WW-1:96]) : $signed({4'b0000, w[32*k +: 32]});
    return PW'(a) * PW'(c);
  endfunction

  logic signed [VW-1:0] base [3];
  logic [31:0]          thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      base[0] <= '0;
      base[1] <= '0;
      base[2] <= '0;
      thr     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        trmt_pkg::REG_BASE_X: base[0] <= cfg_data;
        trmt_pkg::REG_BASE_Y: base[1] <= cfg_data;
        trmt_pkg::REG_BASE_Z: base[2] <= cfg_data;
        trmt_pkg::REG_THR:    thr     <= cfg_data;
        default:              thr     <= thr;
      endcase
    end
  end

  logic en;
  logic skid_full;
  assign en       = !skid_full;
  assign in_ready = en;

  logic [8:0] vld;

  logic signed [VW-1:0] s1_v0 [3], s1_v1 [3];
  logic signed [VW-1:0] s2_v0 [3], s2_v1 [3];
  logic signed [VW-1:0] s3_v0 [3], s3_v1 [3];
  logic signed [VW-1:0] s4_v0 [3], s4_v1 [3];
  logic signed [VW-1:0] s5_v0 [3], s5_v1 [3];
  logic signed [63:0]   s1_p [5][3];  // v0v0, v1v1, v0v1, v0t, v1t
  logic signed [DW-1:0] s2_d [5];
  logic signed [PW-1:0] s3_pp [6][4];
  logic signed [WW-1:0] s4_prod [6];
  logic signed [WW-1:0] s5_d, s5_n0, s5_n1;
  logic signed [PW-1:0] s6_xp [3][3][4];
  logic signed [WW-1:0] s6_d;
  logic                 s6_ok;
  logic signed [NW-1:0] s7_term [3][3];
  logic signed [WW-1:0] s7_d;
  logic                 s7_ok;
  logic signed [NW-1:0] s8_xo [3];
  logic signed [WW-1:0] s8_d;
  logic                 s8_ok;
  logic signed [NW-1:0] s9_xo [3];
  logic signed [WW-1:0] s9_d;
  side_t                s9_side;
  side_t                side [QW];

  logic signed [VW-1:0] in_v0 [3], in_v1 [3];
  assign in_v0 = '{ray0_x, ray0_y, ray0_z};
  assign in_v1 = '{ray1_x, ray1_y, ray1_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[7:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        s1_v0[c]   <= in_v0[c];
        s1_v1[c]   <= in_v1[c];
        s1_p[0][c] <= 64'(in_v0[c]) * 64'(in_v0[c]);
        s1_p[1][c] <= 64'(in_v1[c]) * 64'(in_v1[c]);
        s1_p[2][c] <= 64'(in_v0[c]) * 64'(in_v1[c]);
        s1_p[3][c] <= 64'(in_v0[c]) * 64'(base[c]);
        s1_p[4][c] <= 64'(in_v1[c]) * 64'(base[c]);
      end
      s2_v0 <= s1_v0;
      s2_v1 <= s1_v1;
      for (int j = 0; j < 5; j++) begin
        s2_d[j] <= DW'(s1_p[j][0]) + DW'(s1_p[j][1]) + DW'(s1_p[j][2]);
      end
      s3_v0 <= s2_v0;
      s3_v1 <= s2_v1;
    end
  end

  // Operand pairs: D = p0 - p1, N0 = p2 - p3, N1 = p4 - p5.
  logic signed [DW-1:0] opa [6], opb [6];
  assign opa = '{s2_d[0], s2_d[2], s2_d[1], s2_d[2], s2_d[2], s2_d[0]};
  assign opb = '{s2_d[1], s2_d[2], s2_d[3], s2_d[4], s2_d[3], s2_d[4]};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        s3_pp[j][0] <= pp66(opa[j], opb[j], 1'b0, 1'b0);
        s3_pp[j][1] <= pp66(opa[j], opb[j], 1'b0, 1'b1);
        s3_pp[j][2] <= pp66(opa[j], opb[j], 1'b1, 1'b0);
        s3_pp[j][3] <= pp66(opa[j], opb[j], 1'b1, 1'b1);
      end
      for (int j = 0; j < 6; j++) begin
        s4_prod[j] <= (WW'(s3_pp[j][3]) <<< 64)
                    + ((WW'(s3_pp[j][1]) + WW'(s3_pp[j][2])) <<< 32)
                    + WW'(s3_pp[j][0]);
      end
      s4_v0 <= s3_v0;
      s4_v1 <= s3_v1;
      s5_d  <= s4_prod[0] - s4_prod[1];
      s5_n0 <= s4_prod[2] - s4_prod[3];
      s5_n1 <= s4_prod[4] - s4_prod[5];
      s5_v0 <= s4_v0;
      s5_v1 <= s4_v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 4; k++) begin
          s6_xp[c][0][k] <= ppchunk(s5_v0[c], s5_n0, k);
          s6_xp[c][1][k] <= ppchunk(s5_v1[c], s5_n1, k);
          s6_xp[c][2][k] <= ppchunk(base[c], s5_d, k);
        end
      end
      s6_d  <= s5_d;
      // Drop parallel rays and points behind either camera.
      s6_ok <= !s5_d[WW-1] && (s5_d > $signed({100'b0, thr}))
            && !s5_n0[WW-1] && (s5_n0 != '0)
            && !s5_n1[WW-1] && (s5_n1 != '0);

      for (int c = 0; c < 3; c++) begin
        for (int m = 0; m < 3; m++) begin
          s7_term[c][m] <= NW'(s6_xp[c][m][0])
                         + (NW'(s6_xp[c][m][1]) <<< 32)
                         + (NW'(s6_xp[c][m][2]) <<< 64)
                         + (NW'(s6_xp[c][m][3]) <<< 96);
        end
      end
      s7_d  <= s6_d;
      s7_ok <= s6_ok;

      // Add D for round-to-nearest and D*2^32 to lift the quotient by 2^31.
      for (int c = 0; c < 3; c++) begin
        s8_xo[c] <= s7_term[c][0] + s7_term[c][1] + s7_term[c][2]
                  + NW'(s7_d) + (NW'(s7_d) <<< 32);
      end
      s8_d  <= s7_d;
      s8_ok <= s7_ok;

      s9_xo <= s8_xo;
      s9_d  <= s8_d;
      s9_side.valid <= vld[7];
      s9_side.ok    <= s8_ok;
      for (int c = 0; c < 3; c++) begin
        s9_side.sat_lo[c] <= s8_xo[c][NW-1];
        s9_side.sat_hi[c] <= !s8_xo[c][NW-1] && (s8_xo[c] >= (NW'(s8_d) <<< 33));
      end
    end
  end

  logic [EW-1:0] div_den;
  logic [QW-1:0] quo [3];
  assign div_den = {s9_d[EW-2:0], 1'b0};

  for (genvar c = 0; c < 3; c++) begin : g_div
    trmt_div #(
      .NUM_W(NW),
      .DEN_W(EW),
      .QUO_W(QW)
    ) u_div (
      .clk(clk),
      .en (en),
      .num(s9_xo[c]),
      .den(div_den),
      .quo(quo[c])
    );
  end

  // Sideband runs beside the divider; valid is qualified by vld[8].
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QW; i++) side[i].valid <= 1'b0;
    end else if (en) begin
      side[0].valid  <= s9_side.valid && vld[8];
      side[0].ok     <= s9_side.ok;
      side[0].sat_hi <= s9_side.sat_hi;
      side[0].sat_lo <= s9_side.sat_lo;
      for (int i = 1; i < QW; i++) side[i] <= side[i-1];
    end
  end

  side_t                last;
  logic                 pipe_out;
  logic signed [VW-1:0] res_pt [3];
  assign last     = side[QW-1];
  assign pipe_out = en && last.valid;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (!last.ok) begin
        res_pt[c] = '0;
      end else if (last.sat_lo[c]) begin
        res_pt[c] = {1'b1, {(VW-1){1'b0}}};
      end else if (last.sat_hi[c]) begin
        res_pt[c] = {1'b0, {(VW-1){1'b1}}};
      end else begin
        // Remove the 2^31 lift.
        res_pt[c] = $signed({~quo[c][QW-1], quo[c][QW-2:0]});
      end
    end
  end

  logic signed [VW-1:0] skid_pt [3];
  logic                 skid_pv;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= skid_full || pipe_out;
      skid_full <= 1'b0;
    end else if (pipe_out) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      point_x     <= skid_full ? skid_pt[0] : res_pt[0];
      point_y     <= skid_full ? skid_pt[1] : res_pt[1];
      point_z     <= skid_full ? skid_pt[2] : res_pt[2];
      point_valid <= skid_full ? skid_pv : last.ok;
    end else if (pipe_out) begin
      skid_pt <= res_pt;
      skid_pv <= last.ok;
    end
  end

  `ASSERT_ALWAYS(a_skid_needs_out, skid_full |-> out_valid, "skid holds data with no output")
  `ASSERT_CLK(a_skid_on_stall, $rose(skid_full) |-> $past(out_valid && !out_ready),
              "skid loaded without a stalled output")
  `ASSERT_CLK(a_invalid_is_zero,
              out_valid && !point_valid |-> point_x == 0 && point_y == 0 && point_z == 0,
              "invalid point carries nonzero components")

endmodule
